@@ rtl/core/pattern_replace_stream_core_assert.svh @@
// Assertion macros for the pattern replace core.
`ifndef PATTERN_REPLACE_STREAM_CORE_ASSERT_SVH
`define PATTERN_REPLACE_STREAM_CORE_ASSERT_SVH

// Property checked at every rising clock edge out of reset.
`define PRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen out of reset.
`define PRS_NEVER(lbl, cond, msg) \
  `PRS_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/prs_pkg.sv @@
`default_nettype none
package prs_pkg;

  localparam int NBYTE           = 8;
  localparam int LEN_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_OUTPUT_DEF  = 255;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PLEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PBYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RLEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RBYTES = 2'd3;

  // Lengths already clamped to the pattern limit.
  typedef struct packed {
    logic [LEN_W-1:0]           plen;
    logic [NBYTE-1:0][7:0]      pbytes;
    logic [LEN_W-1:0]           rlen;
    logic [NBYTE-1:0][7:0]      rbytes;
  } cfg_t;

  // One command from the matcher: either a replacement or a list of bytes,
  // optionally closing the string.
  typedef struct packed {
    logic                       repl;
    logic                       last;
    logic [LEN_W-1:0]           n;
    logic [NBYTE-1:0][7:0]      bytes;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/prs_front.sv @@
`default_nettype none
module prs_front
  import prs_pkg::*;
#(
  parameter int MaxPattern = MAX_PATTERN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       clr,
  input  wire logic       acc,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            push,
  output cmd_t            cmd
);

  logic [7:0]       win_r   [MaxPattern];
  logic [7:0]       win_nxt [MaxPattern];
  logic [7:0]       w       [MaxPattern];
  logic [LEN_W-1:0] wcnt_r, wcnt_nxt;
  logic [LEN_W-1:0] cnt1;
  logic             full;
  logic             match;

  always_comb begin
    for (int k = 0; k < MaxPattern; k++) begin
      w[k] = (LEN_W'(k) == wcnt_r) ? in_byte : win_r[k];
    end
    cnt1  = wcnt_r + LEN_W'(1);
    full  = (cnt1 == cfg.plen);
    match = full;
    for (int k = 0; k < MaxPattern; k++) begin
      if ((LEN_W'(k) < cfg.plen) && (w[k] != cfg.pbytes[k])) begin
        match = 1'b0;
      end
    end

    cmd.repl  = 1'b0;
    cmd.last  = in_last;
    cmd.n     = '0;
    cmd.bytes = '0;
    win_nxt   = w;
    wcnt_nxt  = wcnt_r;

    if (cfg.plen == '0) begin
      cmd.n        = LEN_W'(1);
      cmd.bytes[0] = in_byte;
    end else begin
      for (int k = 0; k < MaxPattern; k++) begin
        cmd.bytes[k] = w[k];
      end
      if (match) begin
        cmd.repl = 1'b1;
        wcnt_nxt = '0;
      end else if (full) begin
        cmd.n = in_last ? cfg.plen : LEN_W'(1);
        for (int k = 0; k < MaxPattern - 1; k++) begin
          win_nxt[k] = w[k+1];
        end
        win_nxt[MaxPattern-1] = 8'h00;
        wcnt_nxt = cfg.plen - LEN_W'(1);
      end else begin
        cmd.n    = in_last ? cnt1 : '0;
        wcnt_nxt = cnt1;
      end
      if (in_last) begin
        wcnt_nxt = '0;
      end
    end
    push = acc && (cmd.repl || (cmd.n != '0) || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
    end else if (clr) begin
      wcnt_r <= '0;
    end else if (acc) begin
      wcnt_r <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      win_r <= win_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/prs_queue.sv @@
`default_nettype none
module prs_queue
  import prs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t din,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      nonempty,
  output logic      full
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign dout     = mem_r[rd_r];
  assign nonempty = (cnt_r != '0);
  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + (QPTR_W+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (QPTR_W+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/prs_back.sv @@
`default_nettype none
module prs_back
  import prs_pkg::*;
#(
  parameter int MaxOutput = MAX_OUTPUT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire cmd_t       cmd,
  input  wire logic       cmd_valid,
  output logic            pop,
  output logic            out_req_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_last,
  output logic            out_error
);

  localparam int CNT_W = $clog2(MaxOutput + 1);
  localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] total;
  logic             can_out;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_end;
  logic             skip;
  logic [SUM_W-1:0] sum;

  logic             ov_r;
  logic [7:0]       ob_r;
  logic             odv_r, ol_r, oe_r;

  assign out_req_valid = ov_r;
  assign out_byte      = ob_r;
  assign out_valid     = odv_r;
  assign out_last      = ol_r;
  assign out_error     = oe_r;

  assign can_out = !ov_r || !out_stall;
  assign total   = cmd.repl ? cfg.rlen : cmd.n;
  assign sum     = SUM_W'(count_r) + SUM_W'(total);

  always_comb begin
    pos_nxt   = pos_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    emit      = 1'b0;
    emit_end  = 1'b0;
    emit_byte = cmd.repl ? cfg.rbytes[pos_r[2:0]] : cmd.bytes[pos_r[2:0]];
    skip      = 1'b0;
    pop       = 1'b0;
    if (cmd_valid && can_out) begin
      if (pos_r < total) begin
        if (cmd.repl) begin
          if ((pos_r == '0) && (ovf_r || (sum > SUM_W'(MaxOutput)))) begin
            ovf_nxt = 1'b1;
            skip    = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end else if (ovf_r || (count_r >= CNT_W'(MaxOutput))) begin
          ovf_nxt = 1'b1;
        end else begin
          emit = 1'b1;
        end
        if (emit) begin
          count_nxt = count_r + CNT_W'(1);
        end
        pos_nxt = skip ? total : pos_r + LEN_W'(1);
        if ((skip || (pos_r + LEN_W'(1) == total)) && !cmd.last) begin
          pop     = 1'b1;
          pos_nxt = '0;
        end
      end else begin
        // list done: close the string or just retire an empty command
        emit_end = cmd.last;
        pop      = 1'b1;
        pos_nxt  = '0;
        if (cmd.last) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (emit || emit_end) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit || emit_end) begin
      ob_r  <= emit_end ? 8'h00 : emit_byte;
      odv_r <= !emit_end;
      ol_r  <= emit_end;
      oe_r  <= emit_end && ovf_r;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pattern_replace_stream_core.sv @@
// channel  | handshake                | payload
// ---------+--------------------------+-------------------------------------------
// input    | in_req_valid / in_stall  | in_byte, in_last
// result   | out_req_valid / out_stall| out_byte, out_valid, out_last, out_error
// config   | cfg_we                   | cfg_index, cfg_wdata
//
// One source byte is taken per cycle while the 4-deep command queue has room.
// The emitter sends one result per cycle while out_stall does not hold it: a
// replacement sends its rlen bytes, and a string end sends each flushed byte and
// then the end marker. Dropped bytes over the output limit pass without a result.
// A taken request goes through the command queue before its first result is
// registered. Reset is synchronous; in_stall rises only when the queue is full.
`default_nettype none
module pattern_replace_stream_core
  import prs_pkg::*;
#(
  parameter int MaxPattern = MAX_PATTERN_DEF,
  parameter int MaxOutput  = MAX_OUTPUT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_req_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  in_last,
  output logic                       out_req_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_valid,
  output logic                       out_last,
  output logic                       out_error,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "pattern_replace_stream_core_assert.svh"

  logic [LEN_W-1:0]      plen_r, rlen_r;
  logic [CFG_DATA_W-1:0] pbytes_r, rbytes_r;
  cfg_t                  cfg;
  logic                  clr;
  logic                  acc;
  logic                  q_push, q_pop, q_nonempty, q_full;
  cmd_t                  f_cmd, q_cmd;

  always_comb begin
    cfg.plen   = (plen_r > LEN_W'(MaxPattern)) ? LEN_W'(MaxPattern) : plen_r;
    cfg.rlen   = (rlen_r > LEN_W'(MaxPattern)) ? LEN_W'(MaxPattern) : rlen_r;
    cfg.pbytes = pbytes_r;
    cfg.rbytes = rbytes_r;
  end

  assign clr      = cfg_we && (cfg_index == REG_PLEN);
  assign in_stall = q_full;
  assign acc      = in_req_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r   <= '0;
      pbytes_r <= '0;
      rlen_r   <= '0;
      rbytes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLEN:   plen_r   <= cfg_wdata[LEN_W-1:0];
        REG_PBYTES: pbytes_r <= cfg_wdata;
        REG_RLEN:   rlen_r   <= cfg_wdata[LEN_W-1:0];
        REG_RBYTES: rbytes_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  prs_front #(
    .MaxPattern (MaxPattern)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .clr     (clr),
    .acc     (acc),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (q_push),
    .cmd     (f_cmd)
  );

  prs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .din      (f_cmd),
    .pop      (q_pop),
    .dout     (q_cmd),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  prs_back #(
    .MaxOutput (MaxOutput)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (q_cmd),
    .cmd_valid     (q_nonempty),
    .pop           (q_pop),
    .out_req_valid (out_req_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_valid     (out_valid),
    .out_last      (out_last),
    .out_error     (out_error)
  );

  `PRS_NEVER(a_no_push_full, q_full && q_push, "command pushed into a full queue")
  `PRS_NEVER(a_no_pop_empty, q_pop && !q_nonempty, "command popped from an empty queue")
  `PRS_ASSERT(a_end_marker, out_req_valid && out_last |-> !out_valid && !(|out_byte), "bad marker")
  `PRS_ASSERT(a_error_at_end, out_req_valid && out_error |-> out_last, "error flag outside end marker")

endmodule
`default_nettype wire

@@ verif/pattern_replace_stream_core_tb.sv @@
`timescale 1ns / 100ps
module pattern_replace_stream_core_tb;
  import prs_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 400;
  localparam longint TIMEOUT_NS = 4_800_000;
  localparam logic [3:0] ALL_REGS = 4'b1111;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       error;
  } result_t;

  class replace_scoreboard;
    logic [3:0]  plen_reg;
    logic [3:0]  rlen_reg;
    logic [63:0] pat_reg;
    logic [63:0] rep_reg;
    logic [7:0]  win [prs_pkg::MAX_PATTERN_DEF];
    int          win_cnt;
    int          out_cnt;
    bit          dropped;
    result_t     expected_out [$];
    int          errors;

    function new();
      plen_reg = '0;
      rlen_reg = '0;
      pat_reg = '0;
      rep_reg = '0;
      clear_window();
      out_cnt = 0;
      dropped = 1'b0;
      errors = 0;
    endfunction

    function void clear_window();
      for (int k = 0; k < prs_pkg::MAX_PATTERN_DEF; k++) win[k] = '0;
      win_cnt = 0;
    endfunction

    function int clamp_len(logic [3:0] v);
      return (v > prs_pkg::MAX_PATTERN_DEF) ? prs_pkg::MAX_PATTERN_DEF : int'(v);
    endfunction

    function void push(logic [7:0] d, logic v, logic l, logic e);
      result_t r;
      r.data = d;
      r.valid = v;
      r.last = l;
      r.error = e;
      expected_out.push_back(r);
    endfunction

    function void emit_byte(logic [7:0] b);
      if (dropped) return;
      if (out_cnt + 1 > prs_pkg::MAX_OUTPUT_DEF) begin
        dropped = 1'b1;
        return;
      end
      out_cnt++;
      push(b, 1'b1, 1'b0, 1'b0);
    endfunction

    function void emit_replacement();
      int r;
      r = clamp_len(rlen_reg);
      if (dropped || r == 0) return;
      if (out_cnt + r > prs_pkg::MAX_OUTPUT_DEF) begin
        dropped = 1'b1;
        return;
      end
      for (int k = 0; k < r; k++) begin
        out_cnt++;
        push(rep_reg[8*k +: 8], 1'b1, 1'b0, 1'b0);
      end
    endfunction

    function void shift_oldest();
      if (win_cnt == 0) return;
      emit_byte(win[0]);
      for (int k = 1; k < prs_pkg::MAX_PATTERN_DEF; k++) win[k-1] = win[k];
      win[prs_pkg::MAX_PATTERN_DEF-1] = '0;
      win_cnt--;
    endfunction

    function void write_reg(logic [prs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        prs_pkg::REG_PLEN: begin
          plen_reg = val[3:0];
          clear_window();
        end
        prs_pkg::REG_PBYTES: pat_reg = val;
        prs_pkg::REG_RLEN: rlen_reg = val[3:0];
        prs_pkg::REG_RBYTES: rep_reg = val;
        default: ;
      endcase
    endfunction

    function void note_request(logic [7:0] b, logic last);
      int  plen;
      bit  hit;
      plen = clamp_len(plen_reg);
      if (plen == 0) begin
        emit_byte(b);
      end else begin
        if (win_cnt < prs_pkg::MAX_PATTERN_DEF) begin
          win[win_cnt] = b;
          win_cnt++;
        end
        if (win_cnt >= plen) begin
          hit = 1'b1;
          for (int k = 0; k < plen; k++)
            if (win[k] != pat_reg[8*k +: 8]) hit = 1'b0;
          if (hit) begin
            emit_replacement();
            clear_window();
          end else begin
            shift_oldest();
          end
        end
      end
      if (last) begin
        while (win_cnt > 0) shift_oldest();
        push(8'h00, 1'b0, 1'b1, dropped);
        clear_window();
        out_cnt = 0;
        dropped = 1'b0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(logic [7:0] d, logic v, logic l, logic e);
      result_t want;
      if (expected_out.size() == 0) begin
        report($sformatf("unexpected result byte=%02h valid=%0b last=%0b err=%0b",
                         d, v, l, e));
        return;
      end
      want = expected_out.pop_front();
      if (d !== want.data || v !== want.valid || l !== want.last || e !== want.error)
        report($sformatf("result byte=%02h valid=%0b last=%0b err=%0b, want %02h %0b %0b %0b",
                         d, v, l, e, want.data, want.valid, want.last, want.error));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_req_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte = 8'h00;
  logic                  in_last = 1'b0;
  logic                  out_req_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  out_valid;
  logic                  out_last;
  logic                  out_error;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic        long_hold = 1'b0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          items_sent = 0;
  logic [63:0] reg_val [4];
  logic [7:0]  alpha [4];

  replace_scoreboard sb = new();

  pattern_replace_stream_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req_valid (in_req_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_req_valid(out_req_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .out_error    (out_error),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_req_valid && !out_stall)
        sb.check_result(out_byte, out_valid, out_last, out_error);
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_req_valid && !in_stall) sb.note_request(in_byte, in_last);
    end
  end

  function automatic logic [63:0] len_word(logic [3:0] n);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[3:0] = n;
    return w;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_req_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, wait for all expected results, then let the emitter go quiet
  task automatic settle();
    in_req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input logic [3:0] mask);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_wdata <= reg_val[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // string built mostly from pattern copies and the phase alphabet
  task automatic send_string(input int len, input bit dense, input bit rewrite);
    logic [7:0] str [$];
    int k;
    int pl;
    int pmax;
    int pick;
    int cut;
    pmax = (reg_val[REG_PLEN][3:0] > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF :
           int'(reg_val[REG_PLEN][3:0]);
    while (str.size() < len) begin
      pick = $urandom_range(99);
      if (pmax > 0 && pick < (dense ? 85 : 25)) begin
        pl = (pick % 4 == 0) ? $urandom_range(1, pmax) : pmax;
        for (k = 0; k < pl; k++) str.push_back(reg_val[REG_PBYTES][8*k +: 8]);
      end else if (pick > 90) begin
        str.push_back(8'($urandom_range(255)));
      end else begin
        str.push_back(alpha[$urandom_range(3)]);
      end
    end
    cut = (rewrite && str.size() > 1) ? $urandom_range(1, str.size() - 1) : 0;
    for (k = 0; k < str.size(); k++) begin
      if (cut != 0 && k == cut) begin
        settle();
        reg_val[REG_PLEN] = len_word(4'($urandom_range(15)));
        load_regs(4'(1 << REG_PLEN));
      end
      send_byte(str[k], k == str.size() - 1);
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("pattern_replace_stream_core: mismatch");
    $finish;
  end

  initial begin
    int k;
    int n;
    int pick;
    int phase;
    int base;
    bit expand;

    for (k = 0; k < 4; k++) reg_val[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pass-through at reset config
    send_idle = 15;
    recv_stall = 15;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);
    settle();

    // saturated lengths, full-window match
    reg_val[REG_PLEN] = len_word(4'hF);
    reg_val[REG_PBYTES] = 64'h0807_0605_0403_0201;
    reg_val[REG_RLEN] = len_word(4'hF);
    reg_val[REG_RBYTES] = 64'h8001_FF00_7FFE_C33C;
    load_regs(ALL_REGS);
    for (k = 1; k <= 8; k++) send_byte(8'(k), 1'b0);
    send_byte(8'h09, 1'b1);
    settle();

    // deletion, overlapping candidates, partial window flush
    reg_val[REG_PLEN] = len_word(4'd3);
    reg_val[REG_PBYTES] = {$urandom, $urandom};
    reg_val[REG_PBYTES][23:0] = 24'h414241;
    reg_val[REG_RLEN] = len_word(4'd0);
    load_regs(ALL_REGS);
    for (k = 0; k < 6; k++) send_byte(k[0] ? 8'h42 : 8'h41, k == 5);
    settle();

    // pattern length rewritten mid-string discards the window
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    settle();
    reg_val[REG_PLEN] = len_word(4'd2);
    load_regs(4'(1 << REG_PLEN));
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    settle();

    // long receiver hold while requests keep coming
    send_idle = 0;
    recv_stall = 0;
    fork
      begin
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    for (k = 0; k < 30; k++) send_byte(k[0] ? 8'h42 : 8'($urandom_range(255)), k == 29);
    settle();

    base = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          send_idle = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle = 76;
          recv_stall = 0;
        end
        2: begin
          send_idle = 0;
          recv_stall = 76;
        end
        default: begin
          send_idle = 15;
          recv_stall = 15;
        end
      endcase
      for (k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(255));
      expand = (phase % 5 == 4);
      pick = $urandom_range(9);
      if (expand) n = 1;
      else if (pick == 0) n = 0;
      else if (pick == 1) n = $urandom_range(9, 15);
      else n = $urandom_range(1, 8);
      reg_val[REG_PLEN] = len_word(4'(n));
      for (k = 0; k < 8; k++) reg_val[REG_PBYTES][8*k +: 8] = alpha[$urandom_range(3)];
      reg_val[REG_RLEN] = len_word(expand ? 4'($urandom_range(8, 15)) :
                                            4'($urandom_range(15)));
      reg_val[REG_RBYTES] = {$urandom, $urandom};
      load_regs(ALL_REGS);
      n = expand ? 2 : $urandom_range(2, 5);
      for (k = 0; k < n; k++)
        send_string(expand ? $urandom_range(36, 44) : $urandom_range(1, 24), expand,
                    !expand && $urandom_range(5) == 0);
      settle();
      phase++;
    end

    if (sb.errors == 0) $display("pattern_replace_stream_core: match");
    else $display("pattern_replace_stream_core: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/prs_pkg.sv
rtl/core/prs_front.sv
rtl/core/prs_queue.sv
rtl/core/prs_back.sv
rtl/core/pattern_replace_stream_core.sv
verif/pattern_replace_stream_core_tb.sv
